### rtl/rbs_pkg.sv
// ---------------------------------------------------------------------------
// rbs_pkg
// Shared types, widths and helpers for the ray/box slab intersection unit.
// ---------------------------------------------------------------------------
package rbs_pkg;

   localparam int AXES        = 3;
   localparam int DW          = 32;   // Q16.16 data word
   localparam int SIZE_W      = 31;   // box extent register
   localparam int CSR_IDX_W   = 2;
   localparam int SUM_W       = 64;   // sum of squared direction components
   localparam int ROOT_W      = 32;   // vector length
   localparam int PROD_W      = SIZE_W + DW;
   localparam int HALF_W      = PROD_W - 17;
   localparam int WIDE_W      = 48;   // center +/- half before saturation
   localparam int DIFF_W      = DW + 1;
   localparam int SQRT_BITS   = ROOT_W;
   localparam int NORM_BITS   = 17;   // |n| <= 1.0
   localparam int NREM_W      = DW + 16;
   localparam int RECIP_BITS  = 33;   // 2^32 / |n| needs up to 33 bits
   localparam int RREM_W      = RECIP_BITS;
   localparam int RTRIAL_W    = NORM_BITS + RECIP_BITS - 1;
   localparam int SHIFT_W     = 2 * DW - 16;
   localparam int FRONT_STAGES = 3;
   localparam int SLAB_STAGES  = 5;
   localparam int LATENCY = FRONT_STAGES + SQRT_BITS + NORM_BITS + RECIP_BITS + SLAB_STAGES;

   localparam logic [DW-1:0]     S32_MAX         = 32'h7FFF_FFFF;
   localparam logic [DW-1:0]     S32_MIN         = 32'h8000_0000;
   localparam logic [SIZE_W-1:0] BOX_SIZE_RESET  = 31'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_SIZE_X = 2'd0,
      CSR_BOX_SIZE_Y = 2'd1,
      CSR_BOX_SIZE_Z = 2'd2
   } csr_index_type;

   // per-axis data carried past the front end
   typedef struct packed {
      logic [DW-1:0]     d_mag;
      logic              d_neg;
      logic [DIFF_W-1:0] dl;     // low corner minus origin
      logic [DIFF_W-1:0] dr;     // high corner minus origin
   } rbs_axis_type;
   typedef rbs_axis_type [AXES-1:0] rbs_axes_type;

   typedef struct packed {
      logic              d_neg;
      logic [DIFF_W-1:0] dl;
      logic [DIFF_W-1:0] dr;
   } rbs_slab_side_type;
   typedef rbs_slab_side_type [AXES-1:0] rbs_slabs_type;

   // divider output toward the slab stages
   typedef struct packed {
      logic [RECIP_BITS-1:0] q;
      logic                  n_zero;
      logic                  d_neg;
      logic [DIFF_W-1:0]     dl;
      logic [DIFF_W-1:0]     dr;
   } rbs_recip_type;
   typedef rbs_recip_type [AXES-1:0] rbs_recips_type;

   function automatic logic [DW-1:0] sat_wide(input logic [WIDE_W-1:0] v);
      if (v[WIDE_W-1:DW-1] == {(WIDE_W-DW+1){v[WIDE_W-1]}}) return v[DW-1:0];
      else if (v[WIDE_W-1]) return S32_MIN;
      else return S32_MAX;
   endfunction

endpackage

### rtl/rbs_front.sv
// ---------------------------------------------------------------------------
// rbs_front
// Squares of the direction, half extents, box corners and corner offsets.
// ---------------------------------------------------------------------------
module rbs_front import rbs_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [AXES-1:0][DW-1:0]       origin,
   input  logic [AXES-1:0][DW-1:0]       dir,
   input  logic [AXES-1:0][DW-1:0]       center,
   input  logic [AXES-1:0][DW-1:0]       scale,
   input  logic [AXES-1:0][SIZE_W-1:0]   box_size,
   output logic                          out_valid,
   output logic [SUM_W-1:0]              out_sum,
   output rbs_axes_type                  out_side
);

   // stage 1
   logic                          s1_valid_ff;
   logic [AXES-1:0][SUM_W-1:0]    sq_ff, sq_in;
   logic [AXES-1:0][HALF_W-1:0]   hm_ff, hm_in;
   logic [AXES-1:0][PROD_W-1:0]   hprod;
   logic [AXES-1:0][DW-1:0]       dmag_ff, dmag_in, smag_in, c1_ff, o1_ff;
   logic [AXES-1:0]               sneg_ff, dneg_ff;
   // stage 2
   logic                          s2_valid_ff;
   logic [SUM_W-1:0]              sum01_ff, sum01_in, sq2_ff;
   logic [AXES-1:0][DW-1:0]       lb_ff, lb_in, rt_ff, rt_in, o2_ff, dmag2_ff;
   logic [AXES-1:0]               dneg2_ff;
   logic [AXES-1:0][WIDE_W-1:0]   half_w, cen_w;
   // stage 3
   logic                          s3_valid_ff;
   logic [SUM_W-1:0]              sum_ff;
   rbs_axes_type                  side_ff, side_in;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         dmag_in[a] = dir[a][DW-1] ? (~dir[a] + 1'b1) : dir[a];
         smag_in[a] = scale[a][DW-1] ? (~scale[a] + 1'b1) : scale[a];
         sq_in[a]   = {32'b0, dmag_in[a]} * {32'b0, dmag_in[a]};
         hprod[a]   = {32'b0, box_size[a]} * {31'b0, smag_in[a]};
         hm_in[a]   = hprod[a][PROD_W-1:PROD_W-HALF_W];   // size*|scale|/2
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      sq_ff   <= sq_in;
      hm_ff   <= hm_in;
      dmag_ff <= dmag_in;
      c1_ff   <= center;
      o1_ff   <= origin;
      for (int a = 0; a < AXES; a++) begin
         sneg_ff[a] <= scale[a][DW-1];
         dneg_ff[a] <= dir[a][DW-1];
      end
   end

   always_comb begin
      sum01_in = sq_ff[0] + sq_ff[1];
      for (int a = 0; a < AXES; a++) begin
         half_w[a] = sneg_ff[a] ? -{2'b0, hm_ff[a]} : {2'b0, hm_ff[a]};
         cen_w[a]  = {{(WIDE_W-DW){c1_ff[a][DW-1]}}, c1_ff[a]};
         lb_in[a]  = sat_wide(cen_w[a] - half_w[a]);
         rt_in[a]  = sat_wide(cen_w[a] + half_w[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      sum01_ff <= sum01_in;
      sq2_ff   <= sq_ff[2];
      lb_ff    <= lb_in;
      rt_ff    <= rt_in;
      o2_ff    <= o1_ff;
      dmag2_ff <= dmag_ff;
      dneg2_ff <= dneg_ff;
   end

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         side_in[a].d_mag = dmag2_ff[a];
         side_in[a].d_neg = dneg2_ff[a];
         side_in[a].dl    = {lb_ff[a][DW-1], lb_ff[a]} - {o2_ff[a][DW-1], o2_ff[a]};
         side_in[a].dr    = {rt_ff[a][DW-1], rt_ff[a]} - {o2_ff[a][DW-1], o2_ff[a]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      sum_ff  <= sum01_ff + sq2_ff;
      side_ff <= side_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_sum   = sum_ff;
   assign out_side  = side_ff;

endmodule

### rtl/rbs_sqrt.sv
// ---------------------------------------------------------------------------
// rbs_sqrt
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module rbs_sqrt import rbs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [SUM_W-1:0]   in_sum,
   input  rbs_axes_type       in_side,
   output logic               out_valid,
   output logic [ROOT_W-1:0]  out_len,
   output rbs_axes_type       out_side
);

   localparam int REM_W = SUM_W + 2;

   logic                vld_ff  [1:SQRT_BITS];
   logic [REM_W-1:0]    rem_ff  [1:SQRT_BITS-1];
   logic [ROOT_W-1:0]   root_ff [1:SQRT_BITS];
   rbs_axes_type        side_ff [1:SQRT_BITS];

   for (genvar i = 0; i < SQRT_BITS; i++) begin : g_stage
      localparam int K = SQRT_BITS - 1 - i;
      logic              v_cur;
      logic [REM_W-1:0]  rem_cur;
      logic [ROOT_W-1:0] root_cur;
      rbs_axes_type      side_cur;
      logic [REM_W-1:0]  trial;
      logic              take;

      if (i == 0) begin : g_head
         assign v_cur    = in_valid;
         assign rem_cur  = {2'b0, in_sum};
         assign root_cur = '0;
         assign side_cur = in_side;
      end else begin : g_body
         assign v_cur    = vld_ff[i];
         assign rem_cur  = rem_ff[i];
         assign root_cur = root_ff[i];
         assign side_cur = side_ff[i];
      end

      // (2*root + 2^k) * 2^k, root holding only bits above k
      assign trial = ({(REM_W-ROOT_W)'(0), root_cur} << (K + 1))
                   + ({{(REM_W-1){1'b0}}, 1'b1} << (2 * K));
      assign take  = (rem_cur >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= v_cur;
         end
         side_ff[i+1] <= side_cur;
         root_ff[i+1] <= root_cur | ({{(ROOT_W-1){1'b0}}, take} << K);
      end

      if (i < SQRT_BITS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[i+1] <= take ? (rem_cur - trial) : rem_cur;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_BITS];
   assign out_len   = root_ff[SQRT_BITS];
   assign out_side  = side_ff[SQRT_BITS];

endmodule

### rtl/rbs_divide.sv
// ---------------------------------------------------------------------------
// rbs_divide
// Direction normalize (|d|*2^16/len) and reciprocal (2^32/|n|), both as
// pipelined restoring dividers, three lanes side by side.
// ---------------------------------------------------------------------------
module rbs_divide import rbs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [ROOT_W-1:0]  in_len,
   input  rbs_axes_type       in_side,
   output logic               out_valid,
   output rbs_recips_type     out_recip
);

   // normalize chain
   logic                  nv_ff   [1:NORM_BITS];
   logic [ROOT_W-1:0]     nlen_ff [1:NORM_BITS];
   logic [NREM_W-1:0]     nrem_ff [1:NORM_BITS-1][AXES];
   logic [NORM_BITS-1:0]  nq_ff   [1:NORM_BITS][AXES];
   rbs_slabs_type         nside_ff [1:NORM_BITS];
   // reciprocal chain
   logic                  rv_ff   [1:RECIP_BITS];
   logic [NORM_BITS-1:0]  rm_ff   [1:RECIP_BITS-1][AXES];
   logic [RREM_W-1:0]     rrem_ff [1:RECIP_BITS-1][AXES];
   logic [RECIP_BITS-1:0] rq_ff   [1:RECIP_BITS][AXES];
   logic [AXES-1:0]       rnz_ff  [1:RECIP_BITS];
   rbs_slabs_type         rside_ff [1:RECIP_BITS];

   for (genvar i = 0; i < NORM_BITS; i++) begin : g_norm
      localparam int J = NORM_BITS - 1 - i;
      logic                 v_cur;
      logic [ROOT_W-1:0]    len_cur;
      rbs_slabs_type        side_cur;
      logic [NREM_W-1:0]    rem_cur [AXES];
      logic [NORM_BITS-1:0] q_cur   [AXES];
      logic [NREM_W:0]      trial;
      logic [AXES-1:0]      take;

      if (i == 0) begin : g_head
         always_comb begin
            v_cur   = in_valid;
            len_cur = in_len;
            for (int a = 0; a < AXES; a++) begin
               rem_cur[a]        = {in_side[a].d_mag, 16'b0};
               q_cur[a]          = '0;
               side_cur[a].d_neg = in_side[a].d_neg;
               side_cur[a].dl    = in_side[a].dl;
               side_cur[a].dr    = in_side[a].dr;
            end
         end
      end else begin : g_body
         always_comb begin
            v_cur    = nv_ff[i];
            len_cur  = nlen_ff[i];
            side_cur = nside_ff[i];
            for (int a = 0; a < AXES; a++) begin
               rem_cur[a] = nrem_ff[i][a];
               q_cur[a]   = nq_ff[i][a];
            end
         end
      end

      assign trial = {{(NREM_W+1-ROOT_W){1'b0}}, len_cur} << J;

      always_comb begin
         for (int a = 0; a < AXES; a++) begin
            take[a] = ({1'b0, rem_cur[a]} >= trial);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            nv_ff[i+1] <= 1'b0;
         end else begin
            nv_ff[i+1] <= v_cur;
         end
         nlen_ff[i+1]  <= len_cur;
         nside_ff[i+1] <= side_cur;
         for (int a = 0; a < AXES; a++) begin
            nq_ff[i+1][a] <= q_cur[a] | ({{(NORM_BITS-1){1'b0}}, take[a]} << J);
         end
      end

      if (i < NORM_BITS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            for (int a = 0; a < AXES; a++) begin
               nrem_ff[i+1][a] <= take[a] ? (rem_cur[a] - trial[NREM_W-1:0]) : rem_cur[a];
            end
         end
      end
   end

   for (genvar i = 0; i < RECIP_BITS; i++) begin : g_recip
      localparam int J = RECIP_BITS - 1 - i;
      logic                  v_cur;
      rbs_slabs_type         side_cur;
      logic [AXES-1:0]       nz_cur;
      logic [NORM_BITS-1:0]  m_cur   [AXES];
      logic [RREM_W-1:0]     rem_cur [AXES];
      logic [RECIP_BITS-1:0] q_cur   [AXES];
      logic [RTRIAL_W-1:0]   trial   [AXES];
      logic [AXES-1:0]       take;

      if (i == 0) begin : g_head
         always_comb begin
            v_cur    = nv_ff[NORM_BITS];
            side_cur = nside_ff[NORM_BITS];
            for (int a = 0; a < AXES; a++) begin
               // zero length means a zero direction: every component is 0
               m_cur[a]   = (nlen_ff[NORM_BITS] == '0) ? '0 : nq_ff[NORM_BITS][a];
               nz_cur[a]  = (m_cur[a] == '0);
               rem_cur[a] = {1'b1, {(RREM_W-1){1'b0}}};
               q_cur[a]   = '0;
            end
         end
      end else begin : g_body
         always_comb begin
            v_cur    = rv_ff[i];
            side_cur = rside_ff[i];
            nz_cur   = rnz_ff[i];
            for (int a = 0; a < AXES; a++) begin
               m_cur[a]   = rm_ff[i][a];
               rem_cur[a] = rrem_ff[i][a];
               q_cur[a]   = rq_ff[i][a];
            end
         end
      end

      always_comb begin
         for (int a = 0; a < AXES; a++) begin
            trial[a] = {{(RTRIAL_W-NORM_BITS){1'b0}}, m_cur[a]} << J;
            take[a]  = ({{(RTRIAL_W-RREM_W){1'b0}}, rem_cur[a]} >= trial[a]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[i+1] <= 1'b0;
         end else begin
            rv_ff[i+1] <= v_cur;
         end
         rside_ff[i+1] <= side_cur;
         rnz_ff[i+1]   <= nz_cur;
         for (int a = 0; a < AXES; a++) begin
            rq_ff[i+1][a] <= q_cur[a] | ({{(RECIP_BITS-1){1'b0}}, take[a]} << J);
         end
      end

      if (i < RECIP_BITS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            for (int a = 0; a < AXES; a++) begin
               rm_ff[i+1][a]   <= m_cur[a];
               rrem_ff[i+1][a] <= take[a] ? (rem_cur[a] - trial[a][RREM_W-1:0]) : rem_cur[a];
            end
         end
      end
   end

   always_comb begin
      out_valid = rv_ff[RECIP_BITS];
      for (int a = 0; a < AXES; a++) begin
         out_recip[a].q      = rq_ff[RECIP_BITS][a];
         out_recip[a].n_zero = rnz_ff[RECIP_BITS][a];
         out_recip[a].d_neg  = rside_ff[RECIP_BITS][a].d_neg;
         out_recip[a].dl     = rside_ff[RECIP_BITS][a].dl;
         out_recip[a].dr     = rside_ff[RECIP_BITS][a].dr;
      end
   end

endmodule

### rtl/rbs_slab.sv
// ---------------------------------------------------------------------------
// rbs_slab
// Slab distances per axis, min/max reduce and the hit decision.
// ---------------------------------------------------------------------------
module rbs_slab import rbs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  rbs_recips_type  in_recip,
   output logic            out_valid,
   output logic            out_hit,
   output logic [DW-1:0]   out_distance
);

   function automatic logic [DW-1:0] clamp_t(input logic [SHIFT_W-1:0] p, input logic neg);
      logic [DW-1:0] m;
      m = (p > {{(SHIFT_W-DW){1'b0}}, S32_MIN}) ? S32_MIN : p[DW-1:0];
      if (neg) return ~m + 1'b1;
      else if (m == S32_MIN) return S32_MAX;
      else return m;
   endfunction

   // stage 1: reciprocal saturation and offset magnitudes
   logic                         v1_ff;
   logic [AXES-1:0][DW-1:0]      rmag_ff, rmag_in, lmag_ff, lmag_in, hmag_ff, hmag_in;
   logic [AXES-1:0]              rneg_ff, rneg_in, lneg_ff, hneg_ff;
   logic [AXES-1:0][DIFF_W-1:0]  labs, habs;
   // stage 2: products
   logic                         v2_ff;
   logic [AXES-1:0][SHIFT_W-1:0] pl_ff, ph_ff;
   logic [AXES-1:0][2*DW-1:0]    pl_full, ph_full;
   logic [AXES-1:0]              sl_ff, sh_ff;
   // stage 3: per-axis interval
   logic                         v3_ff;
   logic [AXES-1:0][DW-1:0]      lo_ff, lo_in, hi_ff, hi_in, t1, t2;
   // stage 4: reduce
   logic                         v4_ff;
   logic [DW-1:0]                tmin_ff, tmin_in, tmax_ff, tmax_in;
   // stage 5: result
   logic                         v5_ff;
   logic                         hit_ff;
   logic [DW-1:0]                dist_ff;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         priority if (in_recip[a].n_zero) begin
            rmag_in[a] = S32_MAX;
            rneg_in[a] = 1'b0;
         end else if (in_recip[a].d_neg) begin
            rmag_in[a] = (in_recip[a].q > {1'b0, S32_MIN}) ? S32_MIN : in_recip[a].q[DW-1:0];
            rneg_in[a] = 1'b1;
         end else begin
            rmag_in[a] = (in_recip[a].q > {1'b0, S32_MAX}) ? S32_MAX : in_recip[a].q[DW-1:0];
            rneg_in[a] = 1'b0;
         end
         labs[a]    = in_recip[a].dl[DIFF_W-1] ? (~in_recip[a].dl + 1'b1) : in_recip[a].dl;
         habs[a]    = in_recip[a].dr[DIFF_W-1] ? (~in_recip[a].dr + 1'b1) : in_recip[a].dr;
         lmag_in[a] = labs[a][DW-1:0];
         hmag_in[a] = habs[a][DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      rmag_ff <= rmag_in;
      rneg_ff <= rneg_in;
      lmag_ff <= lmag_in;
      hmag_ff <= hmag_in;
      for (int a = 0; a < AXES; a++) begin
         lneg_ff[a] <= in_recip[a].dl[DIFF_W-1];
         hneg_ff[a] <= in_recip[a].dr[DIFF_W-1];
      end
   end

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         pl_full[a] = {32'b0, lmag_ff[a]} * {32'b0, rmag_ff[a]};
         ph_full[a] = {32'b0, hmag_ff[a]} * {32'b0, rmag_ff[a]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      for (int a = 0; a < AXES; a++) begin
         pl_ff[a] <= pl_full[a][2*DW-1:16];
         ph_ff[a] <= ph_full[a][2*DW-1:16];
         sl_ff[a] <= lneg_ff[a] ^ rneg_ff[a];
         sh_ff[a] <= hneg_ff[a] ^ rneg_ff[a];
      end
   end

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         t1[a] = clamp_t(pl_ff[a], sl_ff[a]);
         t2[a] = clamp_t(ph_ff[a], sh_ff[a]);
         if ($signed(t1[a]) < $signed(t2[a])) begin
            lo_in[a] = t1[a];
            hi_in[a] = t2[a];
         end else begin
            lo_in[a] = t2[a];
            hi_in[a] = t1[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   always_comb begin
      tmin_in = lo_ff[0];
      tmax_in = hi_ff[0];
      for (int a = 1; a < AXES; a++) begin
         if ($signed(lo_ff[a]) > $signed(tmin_in)) tmin_in = lo_ff[a];
         if ($signed(hi_ff[a]) < $signed(tmax_in)) tmax_in = hi_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      tmin_ff <= tmin_in;
      tmax_ff <= tmax_in;
   end

   // miss when the box lies behind or the slabs do not overlap
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      if (tmax_ff[DW-1] || ($signed(tmin_ff) > $signed(tmax_ff))) begin
         hit_ff  <= 1'b0;
         dist_ff <= tmax_ff;
      end else begin
         hit_ff  <= 1'b1;
         dist_ff <= tmin_ff;
      end
   end

   assign out_valid    = v5_ff;
   assign out_hit      = hit_ff;
   assign out_distance = dist_ff;

endmodule

### rtl/ray_box_slab_intersect_unit.sv
// ---------------------------------------------------------------------------
// ray_box_slab_intersect_unit
// Ray against scaled axis-aligned box, slab test in signed Q16.16.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  request  | start, busy          | req_origin/dir/center/scale_x/y/z
//  result   | rsp_valid (strobe)   | rsp_hit, rsp_distance
//  csr      | csr_valid, csr_ready | csr_index, csr_wdata (box_size_x/y/z)
//
//  One beat per cycle sustained. The pipeline depth is dominated by the
//  bit-per-stage square root (32 stages), the normalize divider (17) and
//  the reciprocal divider (33). Synchronous reset clears all valid bits;
//  busy and csr_ready are held off only during reset. Results carry no
//  back-pressure, the pipeline never stalls.
// ---------------------------------------------------------------------------
module ray_box_slab_intersect_unit import rbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [DW-1:0]         req_origin_x,
   input  logic [DW-1:0]         req_origin_y,
   input  logic [DW-1:0]         req_origin_z,
   input  logic [DW-1:0]         req_dir_x,
   input  logic [DW-1:0]         req_dir_y,
   input  logic [DW-1:0]         req_dir_z,
   input  logic [DW-1:0]         req_center_x,
   input  logic [DW-1:0]         req_center_y,
   input  logic [DW-1:0]         req_center_z,
   input  logic [DW-1:0]         req_scale_x,
   input  logic [DW-1:0]         req_scale_y,
   input  logic [DW-1:0]         req_scale_z,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SIZE_W-1:0]     csr_wdata,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic [DW-1:0]         rsp_distance
);

   logic [AXES-1:0][SIZE_W-1:0] box_size_ff;
   logic [AXES-1:0][DW-1:0]     origin, dir, center, scale;
   logic                        accept;
   logic                        fe_valid, sq_valid, dv_valid;
   logic [SUM_W-1:0]            fe_sum;
   rbs_axes_type                fe_side, sq_side;
   logic [ROOT_W-1:0]           sq_len;
   rbs_recips_type              dv_recip;

   assign busy      = reset;
   assign csr_ready = ~reset;
   assign accept    = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_size_ff <= {AXES{BOX_SIZE_RESET}};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BOX_SIZE_X: box_size_ff[0] <= csr_wdata;
            CSR_BOX_SIZE_Y: box_size_ff[1] <= csr_wdata;
            CSR_BOX_SIZE_Z: box_size_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign origin = {req_origin_z, req_origin_y, req_origin_x};
   assign dir    = {req_dir_z, req_dir_y, req_dir_x};
   assign center = {req_center_z, req_center_y, req_center_x};
   assign scale  = {req_scale_z, req_scale_y, req_scale_x};

   rbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .origin    (origin),
      .dir       (dir),
      .center    (center),
      .scale     (scale),
      .box_size  (box_size_ff),
      .out_valid (fe_valid),
      .out_sum   (fe_sum),
      .out_side  (fe_side)
   );

   rbs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_sum    (fe_sum),
      .in_side   (fe_side),
      .out_valid (sq_valid),
      .out_len   (sq_len),
      .out_side  (sq_side)
   );

   rbs_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_len    (sq_len),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_recip (dv_recip)
   );

   rbs_slab u_slab (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (dv_valid),
      .in_recip     (dv_recip),
      .out_valid    (rsp_valid),
      .out_hit      (rsp_hit),
      .out_distance (rsp_distance)
   );

endmodule

### rtl/rbs_checker.sv
// ---------------------------------------------------------------------------
// rbs_checker
// Port-level checks on the intersection unit: latency and reset behavior.
// ---------------------------------------------------------------------------
module rbs_checker import rbs_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic csr_ready,
   input logic rsp_valid
);

   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted beat produced no result at fixed latency");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching request beat");

   a_ready_out_of_reset: assert property (@(posedge clock)
      !reset |-> (!busy && csr_ready))
      else $error("unit not ready outside reset");

endmodule

bind ray_box_slab_intersect_unit rbs_checker u_rbs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .csr_ready (csr_ready),
   .rsp_valid (rsp_valid)
);
